[rtl/core/qau_pkg.sv]
// qau_pkg: shared types, widths, mode codes and the saturation helper
// for the quaternion arithmetic unit; no dependencies
package qau_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // a_i * b_j product, sum of up to four such products
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  // rotate intermediates after the first shift
  localparam int T_W    = SUM_W - FRAC_BITS;
  // intermediate times component, and the final accumulator
  localparam int QPROD_W = T_W + COMP_WIDTH;
  localparam int ACC_W   = (QPROD_W + 2 > SUM_W) ? QPROD_W + 2 : SUM_W;

  // component positions in the per-component arrays
  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;
  localparam int IW = 3;

  localparam logic [2:0] MODE_MUL = 3'd0;
  localparam logic [2:0] MODE_ROT = 3'd1;
  localparam logic [2:0] MODE_DOT = 3'd2;
  localparam logic [2:0] MODE_ADD = 3'd3;
  localparam logic [2:0] MODE_SUB = 3'd4;

  localparam logic signed [COMP_WIDTH-1:0] COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                   mode;
    logic signed [COMP_WIDTH-1:0] a_x;
    logic signed [COMP_WIDTH-1:0] a_y;
    logic signed [COMP_WIDTH-1:0] a_z;
    logic signed [COMP_WIDTH-1:0] a_w;
    logic signed [COMP_WIDTH-1:0] b_x;
    logic signed [COMP_WIDTH-1:0] b_y;
    logic signed [COMP_WIDTH-1:0] b_z;
    logic signed [COMP_WIDTH-1:0] b_w;
  } qau_in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] r_x;
    logic signed [COMP_WIDTH-1:0] r_y;
    logic signed [COMP_WIDTH-1:0] r_z;
    logic signed [COMP_WIDTH-1:0] r_w;
    logic                         saturated;
  } qau_out_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] val;
    logic                         flag;
  } sat_t;

  // clamp a wide signed value to one component
  function automatic sat_t sat_comp(input logic signed [ACC_W-1:0] v);
    sat_t r;
    logic [ACC_W-COMP_WIDTH:0] top;
    top = v[ACC_W-1:COMP_WIDTH-1];
    if (top == '0 || top == '1) begin
      r.val  = v[COMP_WIDTH-1:0];
      r.flag = 1'b0;
    end else begin
      r.val  = v[ACC_W-1] ? COMP_MIN : COMP_MAX;
      r.flag = 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/core/quaternion_arith_unit_core.sv]
// quaternion_arith_unit_core: four-stage fixed-point quaternion datapath
// (product, vector rotate, dot, add, subtract); depends on qau_pkg
// throughput: one transaction per cycle while out_stall is low; stage 1
// forms all sixteen a*b products and the add/subtract sums, stage 2 sums
// the products, stage 3 forms the rotate products, stage 4 sums, shifts
// and saturates into the output register
// reset: rst_n (synchronous) empties every stage; the data registers are not reset
module quaternion_arith_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qau_pkg::qau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qau_pkg::qau_out_t out_data
);
  import qau_pkg::*;

  // stage valids and per-stage load enables
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_valid_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

  // ---------------- stage 1: products ----------------
  logic signed [COMP_WIDTH-1:0] a_in [4];
  logic signed [COMP_WIDTH-1:0] b_in [4];
  logic signed [PROD_W-1:0]     a_ext [4];
  logic signed [PROD_W-1:0]     b_ext [4];
  logic signed [PROD_W-1:0]     p1_nxt [4][4];
  logic signed [COMP_WIDTH:0]   as1_nxt [4];

  logic [2:0]                   mode1_r;
  logic signed [COMP_WIDTH-1:0] a1_r [4];
  logic signed [PROD_W-1:0]     p1_r [4][4];
  logic signed [COMP_WIDTH:0]   as1_r [4];

  always_comb begin
    a_in[IX] = in_data.a_x;
    a_in[IY] = in_data.a_y;
    a_in[IZ] = in_data.a_z;
    a_in[IW] = in_data.a_w;
    b_in[IX] = in_data.b_x;
    b_in[IY] = in_data.b_y;
    b_in[IZ] = in_data.b_z;
    b_in[IW] = in_data.b_w;
    for (int i = 0; i < 4; i++) begin
      a_ext[i] = PROD_W'(a_in[i]);
      b_ext[i] = PROD_W'(b_in[i]);
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_nxt[i][j] = a_ext[i] * b_ext[j];
      end
      if (in_data.mode == MODE_SUB) begin
        as1_nxt[i] = (COMP_WIDTH+1)'(a_in[i]) - (COMP_WIDTH+1)'(b_in[i]);
      end else begin
        as1_nxt[i] = (COMP_WIDTH+1)'(a_in[i]) + (COMP_WIDTH+1)'(b_in[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      mode1_r <= in_data.mode;
      a1_r    <= a_in;
      p1_r    <= p1_nxt;
      as1_r   <= as1_nxt;
    end
  end

  // ---------------- stage 2: sums of products ----------------
  logic signed [SUM_W-1:0] pe [4][4];
  logic signed [SUM_W-1:0] acc2_nxt [4];
  logic signed [SUM_W-1:0] ts [4];
  logic signed [T_W-1:0]   t2_nxt [4];

  logic [2:0]                   mode2_r;
  logic signed [COMP_WIDTH-1:0] a2_r [4];
  logic signed [SUM_W-1:0]      acc2_r [4];
  logic signed [T_W-1:0]        t2_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = SUM_W'(p1_r[i][j]);
      end
    end
    // rotate intermediates, exact sums then floor shift
    ts[IX] = pe[IW][IX] + pe[IY][IZ] - pe[IZ][IY];
    ts[IY] = pe[IW][IY] + pe[IZ][IX] - pe[IX][IZ];
    ts[IZ] = pe[IW][IZ] + pe[IX][IY] - pe[IY][IX];
    ts[IW] = pe[IX][IX] + pe[IY][IY] + pe[IZ][IZ];
    for (int i = 0; i < 4; i++) begin
      t2_nxt[i] = ts[i][SUM_W-1:FRAC_BITS];
      acc2_nxt[i] = '0;
    end
    unique case (mode1_r)
      MODE_MUL: begin
        acc2_nxt[IX] = pe[IW][IX] + pe[IX][IW] + pe[IY][IZ] - pe[IZ][IY];
        acc2_nxt[IY] = pe[IW][IY] + pe[IY][IW] + pe[IZ][IX] - pe[IX][IZ];
        acc2_nxt[IZ] = pe[IW][IZ] + pe[IZ][IW] + pe[IX][IY] - pe[IY][IX];
        acc2_nxt[IW] = pe[IW][IW] - pe[IX][IX] - pe[IY][IY] - pe[IZ][IZ];
      end
      MODE_DOT: begin
        acc2_nxt[IW] = pe[IX][IX] + pe[IY][IY] + pe[IZ][IZ] + pe[IW][IW];
      end
      MODE_ADD, MODE_SUB: begin
        for (int i = 0; i < 4; i++) begin
          acc2_nxt[i] = SUM_W'(as1_r[i]);
        end
      end
      default: begin
        // rotate keeps its sums in the intermediates; unused codes give zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      mode2_r <= mode1_r;
      a2_r    <= a1_r;
      acc2_r  <= acc2_nxt;
      t2_r    <= t2_nxt;
    end
  end

  // ---------------- stage 3: rotate products ----------------
  logic signed [QPROD_W-1:0] te [4];
  logic signed [QPROD_W-1:0] ae [4];
  logic signed [QPROD_W-1:0] q3_nxt [3][4];

  logic [2:0]                mode3_r;
  logic signed [SUM_W-1:0]   acc3_r [4];
  logic signed [QPROD_W-1:0] q3_r [3][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      te[i] = QPROD_W'(t2_r[i]);
      ae[i] = QPROD_W'(a2_r[i]);
    end
    // terms in order: +, +, -, +
    q3_nxt[IX][0] = te[IW] * ae[IX];
    q3_nxt[IX][1] = te[IX] * ae[IW];
    q3_nxt[IX][2] = te[IY] * ae[IZ];
    q3_nxt[IX][3] = te[IZ] * ae[IY];
    q3_nxt[IY][0] = te[IW] * ae[IY];
    q3_nxt[IY][1] = te[IY] * ae[IW];
    q3_nxt[IY][2] = te[IZ] * ae[IX];
    q3_nxt[IY][3] = te[IX] * ae[IZ];
    q3_nxt[IZ][0] = te[IW] * ae[IZ];
    q3_nxt[IZ][1] = te[IZ] * ae[IW];
    q3_nxt[IZ][2] = te[IX] * ae[IY];
    q3_nxt[IZ][3] = te[IY] * ae[IX];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3 && v2_r) begin
      mode3_r <= mode2_r;
      acc3_r  <= acc2_r;
      q3_r    <= q3_nxt;
    end
  end

  // ---------------- stage 4: final sum, shift, saturate ----------------
  logic signed [ACC_W-1:0] f4 [4];
  logic signed [ACC_W-1:0] fs4 [4];
  logic signed [ACC_W-1:0] qe [3][4];
  sat_t                    s4 [4];
  logic                    do_shift;
  qau_out_t                out_nxt;
  qau_out_t                out_data_r;

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      for (int k = 0; k < 4; k++) begin
        qe[o][k] = ACC_W'(q3_r[o][k]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      f4[i] = ACC_W'(acc3_r[i]);
    end
    if (mode3_r == MODE_ROT) begin
      for (int o = 0; o < 3; o++) begin
        f4[o] = qe[o][0] + qe[o][1] - qe[o][2] + qe[o][3];
      end
      f4[IW] = '0;
    end
    // add and subtract are not rescaled
    do_shift = (mode3_r == MODE_MUL) || (mode3_r == MODE_ROT) || (mode3_r == MODE_DOT);
    for (int i = 0; i < 4; i++) begin
      fs4[i] = do_shift ? (f4[i] >>> FRAC_BITS) : f4[i];
      s4[i]  = sat_comp(fs4[i]);
    end
    out_nxt.r_x       = s4[IX].val;
    out_nxt.r_y       = s4[IY].val;
    out_nxt.r_z       = s4[IZ].val;
    out_nxt.r_w       = s4[IW].val;
    out_nxt.saturated = s4[IX].flag | s4[IY].flag | s4[IZ].flag | s4[IW].flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= v3_r;
    end
    if (rdy4 && v3_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

[dv/tb_quaternion_arith_unit_core.sv]
// self-checking testbench for quaternion_arith_unit_core: directed corners, then random
// transactions with random idling on both sides; depends on qau_pkg and the core rtl
`timescale 1ns / 1ps

module tb_quaternion_arith_unit_core;
  import qau_pkg::*;

  localparam int MODE_SPARE_MAX = 7;      // highest unused mode code
  localparam int Q_MAX = 32767;
  localparam int Q_MIN = -32768;
  localparam int Q_ONE = 1 << FRAC_BITS;
  localparam int RANDOM_OPS = 1750;
  localparam int HOLD_AT_RESULT = 600;    // where the long receiver hold-off starts
  localparam int HOLD_CYCLES = 150;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  qau_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  qau_out_t out_data;

  qau_in_t  op_queue[$];
  qau_out_t predicted_results[$];
  qau_out_t want;
  int       ops_queued = 0;
  int       ops_accepted = 0;
  int       errors = 0;
  int       send_gap = 0;
  int       send_burst = 0;
  int       recv_burst = 0;
  int       hold_left = 0;
  int       results_taken = 0;
  bit       long_hold_done = 1'b0;

  quaternion_arith_unit_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shift is arithmetic on longint, so it floors like the hardware
  function automatic logic signed [COMP_WIDTH-1:0] clamp_comp(input longint v,
                                                               inout logic hit);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) begin
      hit = 1'b1;
      return hi_lim[COMP_WIDTH-1:0];
    end
    if (v < lo_lim) begin
      hit = 1'b1;
      return lo_lim[COMP_WIDTH-1:0];
    end
    return v[COMP_WIDTH-1:0];
  endfunction

  function automatic qau_out_t compute_quat_result(input qau_in_t op);
    qau_out_t r;
    longint   ax, ay, az, aw, bx, by, bz, bw;
    longint   tx, ty, tz, tw;
    logic     hit;
    ax = longint'(op.a_x); ay = longint'(op.a_y);
    az = longint'(op.a_z); aw = longint'(op.a_w);
    bx = longint'(op.b_x); by = longint'(op.b_y);
    bz = longint'(op.b_z); bw = longint'(op.b_w);
    hit = 1'b0;
    r = '0;
    case (op.mode)
      MODE_MUL: begin
        r.r_x = clamp_comp((aw * bx + ax * bw + ay * bz - az * by) >>> FRAC_BITS, hit);
        r.r_y = clamp_comp((aw * by + ay * bw + az * bx - ax * bz) >>> FRAC_BITS, hit);
        r.r_z = clamp_comp((aw * bz + az * bw + ax * by - ay * bx) >>> FRAC_BITS, hit);
        r.r_w = clamp_comp((aw * bw - ax * bx - ay * by - az * bz) >>> FRAC_BITS, hit);
      end
      MODE_ROT: begin
        // first stage stays wide and unclamped, b_w plays no part
        tx = (aw * bx + ay * bz - az * by) >>> FRAC_BITS;
        ty = (aw * by + az * bx - ax * bz) >>> FRAC_BITS;
        tz = (aw * bz + ax * by - ay * bx) >>> FRAC_BITS;
        tw = (ax * bx + ay * by + az * bz) >>> FRAC_BITS;
        r.r_x = clamp_comp((tw * ax + tx * aw - ty * az + tz * ay) >>> FRAC_BITS, hit);
        r.r_y = clamp_comp((tw * ay + ty * aw - tz * ax + tx * az) >>> FRAC_BITS, hit);
        r.r_z = clamp_comp((tw * az + tz * aw - tx * ay + ty * ax) >>> FRAC_BITS, hit);
      end
      MODE_DOT: begin
        r.r_w = clamp_comp((ax * bx + ay * by + az * bz + aw * bw) >>> FRAC_BITS, hit);
      end
      MODE_ADD: begin
        r.r_x = clamp_comp(ax + bx, hit);
        r.r_y = clamp_comp(ay + by, hit);
        r.r_z = clamp_comp(az + bz, hit);
        r.r_w = clamp_comp(aw + bw, hit);
      end
      MODE_SUB: begin
        r.r_x = clamp_comp(ax - bx, hit);
        r.r_y = clamp_comp(ay - by, hit);
        r.r_z = clamp_comp(az - bz, hit);
        r.r_w = clamp_comp(aw - bw, hit);
      end
      default: begin
        r = '0;
      end
    endcase
    r.saturated = hit;
    return r;
  endfunction

  // mostly no gap, some short ones, a few long, and now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 65535) - 32768;
    if (r < 8) return $urandom_range(0, 2 * Q_ONE) - Q_ONE;
    if (r == 8) return ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
    return $urandom_range(0, 2) - 1;
  endfunction

  task automatic queue_op(input int m, input int ax, input int ay, input int az,
                          input int aw, input int bx, input int by, input int bz,
                          input int bw);
    qau_in_t op;
    op.mode = 3'(m);
    op.a_x = COMP_WIDTH'(ax); op.a_y = COMP_WIDTH'(ay);
    op.a_z = COMP_WIDTH'(az); op.a_w = COMP_WIDTH'(aw);
    op.b_x = COMP_WIDTH'(bx); op.b_y = COMP_WIDTH'(by);
    op.b_z = COMP_WIDTH'(bz); op.b_w = COMP_WIDTH'(bw);
    op_queue.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_random_op();
    int m;
    if ($urandom_range(0, 99) < 4) m = $urandom_range(MODE_SUB + 1, MODE_SPARE_MAX);
    else m = $urandom_range(MODE_MUL, MODE_SUB);
    queue_op(m, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // sender stays idle until every queued transaction has its result back
  task automatic drain_results();
    while (ops_accepted != ops_queued || predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(compute_quat_result(in_data));
        ops_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || op_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_valid <= 1'b1;
          in_data <= op_queue.pop_front();
          send_gap = pick_gap(send_burst);
        end
      end
    end
  end

  // receiver stall, with one long hold-off so the pipe backs up into in_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if (!long_hold_done && results_taken >= HOLD_AT_RESULT) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        hold_left = pick_gap(recv_burst);
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction with nothing pending: %p", out_data);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("r_x", int'(want.r_x), int'(out_data.r_x));
        check_field("r_y", int'(want.r_y), int'(out_data.r_y));
        check_field("r_z", int'(want.r_z), int'(out_data.r_z));
        check_field("r_w", int'(want.r_w), int'(out_data.r_w));
        check_field("saturated", int'(want.saturated), int'(out_data.saturated));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corners of every mode: all max, all min, and min against max
    for (int m = MODE_MUL; m <= MODE_SUB; m++) begin
      queue_op(m, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      queue_op(m, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      queue_op(m, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    end
    // identity rotation, with a b_w that must be ignored
    queue_op(MODE_ROT, 0, 0, 0, Q_ONE, 1234, -2345, 3456, Q_MIN);
    queue_op(MODE_MUL, 0, 0, 0, Q_ONE, -77, 4096, -8192, 300);
    queue_op(MODE_DOT, 0, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    // unused mode codes give all zeros
    for (int m = MODE_SUB + 1; m <= MODE_SPARE_MAX; m++) begin
      queue_op(m, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    end
    drain_results();

    for (int i = 0; i < RANDOM_OPS / 2; i++) queue_random_op();
    drain_results();
    for (int i = RANDOM_OPS / 2; i < RANDOM_OPS; i++) queue_random_op();
    drain_results();

    repeat (20) @(posedge clk);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
